### src/ccfr_pkg.sv
// Shared types and constants of the framed receiver with CRC-16 check.
// Used by the serial CRC unit and by the top level; no dependencies.
package ccfr_pkg;

    typedef enum logic [6:0] {
        PH_HUNT    = 7'b0000001,
        PH_LEN     = 7'b0000010,
        PH_CMD     = 7'b0000100,
        PH_PAYLOAD = 7'b0001000,
        PH_CRC_HI  = 7'b0010000,
        PH_CRC_LO  = 7'b0100000,
        PH_EMIT    = 7'b1000000
    } phase_t;

    typedef enum logic [1:0] {
        EV_GOOD    = 2'd0,
        EV_CRC_ERR = 2'd1,
        EV_LEN_ERR = 2'd2
    } event_t;

    localparam logic CFG_START_BYTE = 1'b0;
    localparam logic CFG_MAX_LENGTH = 1'b1;

    localparam logic [7:0]  START_BYTE_RESET = 8'hAA;
    localparam logic [5:0]  MAX_LENGTH_RESET = 6'd32;
    localparam logic [15:0] CRC_POLY         = 16'h1021;
    localparam logic [15:0] CRC_INIT         = 16'hFFFF;
    localparam logic [3:0]  BITS_PER_BYTE    = 4'd8;

    typedef struct packed {
        logic start;
        logic seed;
    } crc_ctl_t;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [5:0]  frame_length;
        logic [7:0]  command;
        logic [4:0]  byte_index;
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic        last;
        logic [31:0] good_frames;
        logic [31:0] bad_frames;
    } result_t;

endpackage

### src/ccfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; contents are not reset.
module ccfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/ccfr_crc_serial.sv
// Bit-serial CRC-16 (poly 0x1021, MSB first): one bit per cycle, eight per byte.
// Depends on ccfr_pkg for the control struct and CRC constants.
module ccfr_crc_serial (
    input  logic               aclk,
    input  logic               aresetn,
    input  ccfr_pkg::crc_ctl_t ctl,
    input  logic [7:0]         data_in,
    output logic [15:0]        crc,
    output logic               busy
);
    import ccfr_pkg::*;

    logic [15:0] crc_reg, crc_next;
    logic [7:0]  shift_reg, shift_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        fb;

    always_comb begin
        crc_next   = crc_reg;
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        fb         = crc_reg[15] ^ shift_reg[7];
        if (ctl.start) begin
            crc_next   = ctl.seed ? CRC_INIT : crc_reg;
            shift_next = data_in;
            cnt_next   = BITS_PER_BYTE;
        end else if (cnt_reg != 4'd0) begin
            crc_next   = {crc_reg[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
            shift_next = {shift_reg[6:0], 1'b0};
            cnt_next   = cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= '0;
            cnt_reg <= '0;
        end else begin
            crc_reg <= crc_next;
            cnt_reg <= cnt_next;
        end
        shift_reg <= shift_next;
    end

    assign crc  = crc_reg;
    assign busy = (cnt_reg != 4'd0);

endmodule

### src/crc_checked_frame_receiver_top.sv
// Framed byte receiver with CRC-16 check: top level.
// Depends on ccfr_pkg, ccfr_crc_serial and ccfr_ram.
//
// Input channel (s_valid/s_ready/s_rx_byte) takes one received byte per
// request. The block hunts for start_byte, then reads length, command,
// payload and a big-endian CRC-16 over length, command and payload.
// A valid length byte and the command and payload bytes each start the
// bit-serial CRC unit, which keeps s_ready low while it shifts the byte in.
// Start and CRC bytes do not go through the CRC unit.
// Result channel (m_valid/m_ready/m_*) is a single output register. A good
// frame yields one result per payload byte, or one for an empty payload; an
// error yields one result. Error and empty-frame results are valid the cycle
// after their request; each payload result is read from the payload RAM
// (registered read) once the output register is free, then loaded into it.
// A length or CRC low byte is held off while a result waits, and all input
// is held off during emission. Counters wrap at 2^32.
// Configuration (cfg_we/cfg_index/cfg_wdata) writes start_byte (index 0)
// and max_length (index 1). Reset (aresetn low, synchronous) returns to
// the hunt, clears counters and restores register defaults.
module crc_checked_frame_receiver_top #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_event_res,
    output logic [5:0]  m_frame_length,
    output logic [7:0]  m_command,
    output logic [4:0]  m_byte_index,
    output logic [7:0]  m_payload_byte,
    output logic        m_payload_valid,
    output logic        m_last,
    output logic [31:0] m_good_frames,
    output logic [31:0] m_bad_frames,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_wdata
);
    import ccfr_pkg::*;

    localparam int         AW     = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [8:0] MaxPay = 9'(MAX_PAYLOAD);

    phase_t      phase_reg, phase_next;
    logic [7:0]  start_byte_reg, start_byte_next;
    logic [5:0]  max_length_reg, max_length_next;
    logic [7:0]  crc_hi_reg, crc_hi_next;
    logic [5:0]  bytes_rx_reg, bytes_rx_next;
    logic [5:0]  held_len_reg, held_len_next;
    logic [7:0]  held_cmd_reg, held_cmd_next;
    logic [31:0] good_count_reg, good_count_next;
    logic [31:0] bad_count_reg, bad_count_next;
    logic [5:0]  emit_idx_reg, emit_idx_next;
    logic        rd_pend_reg, rd_pend_next;
    logic        m_valid_reg, m_valid_next;
    result_t     out_reg, out_next;

    crc_ctl_t    crc_ctl;
    logic [15:0] crc_value;
    logic        crc_busy;
    logic        ram_we, ram_re;
    logic [7:0]  ram_q;
    logic        acc;
    logic [8:0]  limit;
    logic        bad_len;
    logic        crc_ok;
    logic [5:0]  bytes_rx_inc;
    logic [5:0]  emit_idx_inc;
    logic        out_free;

    ccfr_crc_serial u_crc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (crc_ctl),
        .data_in (s_rx_byte),
        .crc     (crc_value),
        .busy    (crc_busy)
    );

    ccfr_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD),
        .AW    (AW)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (AW'(bytes_rx_reg)),
        .wdata (s_rx_byte),
        .re    (ram_re),
        .raddr (AW'(emit_idx_reg)),
        .rdata (ram_q)
    );

    assign s_ready = (phase_reg != PH_EMIT) && !crc_busy &&
                     !(m_valid_reg && ((phase_reg == PH_LEN) || (phase_reg == PH_CRC_LO)));
    assign acc      = s_valid && s_ready;
    assign limit    = (MaxPay < {3'b000, max_length_reg}) ? MaxPay : {3'b000, max_length_reg};
    assign bad_len  = ({1'b0, s_rx_byte} > limit);
    assign crc_ok   = ({crc_hi_reg, s_rx_byte} == crc_value);
    assign bytes_rx_inc = bytes_rx_reg + 6'd1;
    assign emit_idx_inc = emit_idx_reg + 6'd1;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        phase_next      = phase_reg;
        start_byte_next = start_byte_reg;
        max_length_next = max_length_reg;
        crc_hi_next     = crc_hi_reg;
        bytes_rx_next   = bytes_rx_reg;
        held_len_next   = held_len_reg;
        held_cmd_next   = held_cmd_reg;
        good_count_next = good_count_reg;
        bad_count_next  = bad_count_reg;
        emit_idx_next   = emit_idx_reg;
        rd_pend_next    = rd_pend_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        out_next        = out_reg;
        crc_ctl         = '0;
        ram_we          = 1'b0;
        ram_re          = 1'b0;

        if (cfg_we) begin
            unique case (cfg_index)
                CFG_START_BYTE: start_byte_next = cfg_wdata;
                CFG_MAX_LENGTH: max_length_next = cfg_wdata[5:0];
            endcase
        end

        unique case (phase_reg)
            PH_HUNT: begin
                if (acc && (s_rx_byte == start_byte_reg)) begin
                    phase_next = PH_LEN;
                end
            end
            PH_LEN: begin
                if (acc) begin
                    if (bad_len) begin
                        phase_next          = PH_HUNT;
                        bad_count_next      = bad_count_reg + 32'd1;
                        m_valid_next        = 1'b1;
                        out_next            = '0;
                        out_next.event_res  = EV_LEN_ERR;
                        out_next.last       = 1'b1;
                        out_next.good_frames = good_count_reg;
                        out_next.bad_frames = bad_count_reg + 32'd1;
                    end else begin
                        held_len_next = s_rx_byte[5:0];
                        crc_ctl.start = 1'b1;
                        crc_ctl.seed  = 1'b1;
                        phase_next    = PH_CMD;
                    end
                end
            end
            PH_CMD: begin
                if (acc) begin
                    held_cmd_next = s_rx_byte;
                    crc_ctl.start = 1'b1;
                    bytes_rx_next = '0;
                    phase_next    = (held_len_reg != 6'd0) ? PH_PAYLOAD : PH_CRC_HI;
                end
            end
            PH_PAYLOAD: begin
                if (acc) begin
                    ram_we        = 1'b1;
                    crc_ctl.start = 1'b1;
                    bytes_rx_next = bytes_rx_inc;
                    if (bytes_rx_inc >= held_len_reg) begin
                        phase_next = PH_CRC_HI;
                    end
                end
            end
            PH_CRC_HI: begin
                if (acc) begin
                    crc_hi_next = s_rx_byte;
                    phase_next  = PH_CRC_LO;
                end
            end
            PH_CRC_LO: begin
                if (acc) begin
                    phase_next = PH_HUNT;
                    if (!crc_ok) begin
                        bad_count_next       = bad_count_reg + 32'd1;
                        m_valid_next         = 1'b1;
                        out_next             = '0;
                        out_next.event_res   = EV_CRC_ERR;
                        out_next.last        = 1'b1;
                        out_next.good_frames = good_count_reg;
                        out_next.bad_frames  = bad_count_reg + 32'd1;
                    end else begin
                        good_count_next = good_count_reg + 32'd1;
                        if (held_len_reg == 6'd0) begin
                            m_valid_next         = 1'b1;
                            out_next             = '0;
                            out_next.event_res   = EV_GOOD;
                            out_next.command     = held_cmd_reg;
                            out_next.last        = 1'b1;
                            out_next.good_frames = good_count_reg + 32'd1;
                            out_next.bad_frames  = bad_count_reg;
                        end else begin
                            phase_next    = PH_EMIT;
                            emit_idx_next = '0;
                            rd_pend_next  = 1'b0;
                        end
                    end
                end
            end
            PH_EMIT: begin
                if (rd_pend_reg) begin
                    m_valid_next           = 1'b1;
                    out_next.event_res     = EV_GOOD;
                    out_next.frame_length  = held_len_reg;
                    out_next.command       = held_cmd_reg;
                    out_next.byte_index    = emit_idx_reg[4:0];
                    out_next.payload_byte  = ram_q;
                    out_next.payload_valid = 1'b1;
                    out_next.last          = (emit_idx_inc == held_len_reg);
                    out_next.good_frames   = good_count_reg;
                    out_next.bad_frames    = bad_count_reg;
                    emit_idx_next          = emit_idx_inc;
                    rd_pend_next           = 1'b0;
                    if (emit_idx_inc == held_len_reg) begin
                        phase_next = PH_HUNT;
                    end
                end else if (out_free) begin
                    ram_re       = 1'b1;
                    rd_pend_next = 1'b1;
                end
            end
            default: phase_next = PH_HUNT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HUNT;
            start_byte_reg <= START_BYTE_RESET;
            max_length_reg <= MAX_LENGTH_RESET;
            crc_hi_reg     <= '0;
            bytes_rx_reg   <= '0;
            held_len_reg   <= '0;
            held_cmd_reg   <= '0;
            good_count_reg <= '0;
            bad_count_reg  <= '0;
            emit_idx_reg   <= '0;
            rd_pend_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            start_byte_reg <= start_byte_next;
            max_length_reg <= max_length_next;
            crc_hi_reg     <= crc_hi_next;
            bytes_rx_reg   <= bytes_rx_next;
            held_len_reg   <= held_len_next;
            held_cmd_reg   <= held_cmd_next;
            good_count_reg <= good_count_next;
            bad_count_reg  <= bad_count_next;
            emit_idx_reg   <= emit_idx_next;
            rd_pend_reg    <= rd_pend_next;
            m_valid_reg    <= m_valid_next;
        end
        out_reg <= out_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_event_res     = out_reg.event_res;
    assign m_frame_length  = out_reg.frame_length;
    assign m_command       = out_reg.command;
    assign m_byte_index    = out_reg.byte_index;
    assign m_payload_byte  = out_reg.payload_byte;
    assign m_payload_valid = out_reg.payload_valid;
    assign m_last          = out_reg.last;
    assign m_good_frames   = out_reg.good_frames;
    assign m_bad_frames    = out_reg.bad_frames;

    a_len_starts_crc: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && (phase_reg == PH_LEN) && !bad_len) |=> crc_busy)
        else $error("length byte did not start the CRC unit");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(out_reg)))
        else $error("stalled result changed");

    a_error_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_event_res != EV_GOOD)) |-> (m_last && !m_payload_valid))
        else $error("error result not marked last");

    a_emit_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_EMIT) |-> ((held_len_reg != 6'd0) && (emit_idx_reg < held_len_reg)))
        else $error("emission index out of range");

    a_no_load_over_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_pend_reg && (phase_reg == PH_EMIT)) |-> !(m_valid_reg && !$past(out_free)))
        else $error("payload result loaded over a full output register");

endmodule

### verif/ccfr_scoreboard_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the CRC-checked frame receiver: byte-level frame predictor
// and result comparison. Depends on ccfr_pkg for phase, event and result types.
package ccfr_scoreboard_pkg;

    import ccfr_pkg::*;

    localparam int PAYLOAD_DEPTH = 32;

    function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    class frame_scoreboard;
        logic [7:0]  start_byte;
        logic [5:0]  max_length;
        phase_t      rx_phase;
        logic [15:0] crc_acc;
        logic [7:0]  crc_msb;
        logic [5:0]  payload_count;
        logic [5:0]  frame_len;
        logic [7:0]  frame_cmd;
        logic [7:0]  payload_mem [PAYLOAD_DEPTH];
        logic [31:0] good_total;
        logic [31:0] bad_total;
        result_t     awaited_results [$];
        int          error_count;
        int          results_checked;

        function new();
            start_byte      = START_BYTE_RESET;
            max_length      = MAX_LENGTH_RESET;
            rx_phase        = PH_HUNT;
            crc_acc         = '0;
            crc_msb         = '0;
            payload_count   = '0;
            frame_len       = '0;
            frame_cmd       = '0;
            good_total      = '0;
            bad_total       = '0;
            error_count     = 0;
            results_checked = 0;
        endfunction

        function void write_register(logic idx, logic [7:0] value);
            if (idx == CFG_START_BYTE) begin
                start_byte = value;
            end else begin
                max_length = value[5:0];
            end
        endfunction

        function void queue_result(event_t ev, logic [5:0] len, logic [7:0] cmd,
                                   logic [4:0] idx, logic [7:0] data, logic valid,
                                   logic last_flag);
            result_t r;
            r.event_res     = ev;
            r.frame_length  = len;
            r.command       = cmd;
            r.byte_index    = idx;
            r.payload_byte  = data;
            r.payload_valid = valid;
            r.last          = last_flag;
            r.good_frames   = good_total;
            r.bad_frames    = bad_total;
            awaited_results.push_back(r);
        endfunction

        function void note_rx_byte(logic [7:0] b);
            int limit;
            case (rx_phase)
                PH_LEN: begin
                    limit = (max_length > PAYLOAD_DEPTH) ? PAYLOAD_DEPTH : max_length;
                    if (b > limit) begin
                        rx_phase = PH_HUNT;
                        bad_total++;
                        queue_result(EV_LEN_ERR, '0, '0, '0, '0, 1'b0, 1'b1);
                    end else begin
                        frame_len = b[5:0];
                        crc_acc   = crc16_next(CRC_INIT, b);
                        rx_phase  = PH_CMD;
                    end
                end
                PH_CMD: begin
                    frame_cmd     = b;
                    crc_acc       = crc16_next(crc_acc, b);
                    payload_count = '0;
                    rx_phase      = (frame_len != 0) ? PH_PAYLOAD : PH_CRC_HI;
                end
                PH_PAYLOAD: begin
                    payload_mem[payload_count[4:0]] = b;
                    crc_acc = crc16_next(crc_acc, b);
                    payload_count++;
                    if (payload_count >= frame_len) rx_phase = PH_CRC_HI;
                end
                PH_CRC_HI: begin
                    crc_msb  = b;
                    rx_phase = PH_CRC_LO;
                end
                PH_CRC_LO: begin
                    rx_phase = PH_HUNT;
                    if ({crc_msb, b} != crc_acc) begin
                        bad_total++;
                        queue_result(EV_CRC_ERR, '0, '0, '0, '0, 1'b0, 1'b1);
                    end else begin
                        good_total++;
                        if (frame_len == 0) begin
                            queue_result(EV_GOOD, '0, frame_cmd, '0, '0, 1'b0, 1'b1);
                        end else begin
                            for (int i = 0; i < frame_len; i++) begin
                                queue_result(EV_GOOD, frame_len, frame_cmd, 5'(i),
                                             payload_mem[i], 1'b1, (i + 1 == frame_len));
                            end
                        end
                    end
                end
                default: begin
                    rx_phase = (b == start_byte) ? PH_LEN : PH_HUNT;
                end
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] expected, logic [31:0] actual);
            if (expected !== actual) begin
                $error("%s: expected %0h, got %0h", name, expected, actual);
                error_count++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (awaited_results.size() == 0) begin
                $error("result with no pending request: event_res %0d", got.event_res);
                error_count++;
                return;
            end
            want = awaited_results.pop_front();
            results_checked++;
            compare_field("event_res", want.event_res, got.event_res);
            compare_field("frame_length", want.frame_length, got.frame_length);
            compare_field("command", want.command, got.command);
            compare_field("byte_index", want.byte_index, got.byte_index);
            compare_field("payload_byte", want.payload_byte, got.payload_byte);
            compare_field("payload_valid", want.payload_valid, got.payload_valid);
            compare_field("last", want.last, got.last);
            compare_field("good_frames", want.good_frames, got.good_frames);
            compare_field("bad_frames", want.bad_frames, got.bad_frames);
        endfunction

        function int pending_count();
            return awaited_results.size();
        endfunction
    endclass

endpackage

### verif/crc_checked_frame_receiver_top_test.sv
`timescale 1ns / 1ps
// Testbench top for crc_checked_frame_receiver_top: drives framed byte traffic,
// configuration writes and backpressure. Depends on ccfr_pkg and ccfr_scoreboard_pkg.
module crc_checked_frame_receiver_top_test;

    import ccfr_pkg::*;
    import ccfr_scoreboard_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 500;
    localparam int SETTLE_CYCLES = 40;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic [1:0]  m_event_res;
    logic [5:0]  m_frame_length;
    logic [7:0]  m_command;
    logic [4:0]  m_byte_index;
    logic [7:0]  m_payload_byte;
    logic        m_payload_valid;
    logic        m_last;
    logic [31:0] m_good_frames;
    logic [31:0] m_bad_frames;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = 1'b0;
    logic [7:0]  cfg_wdata = 8'h00;

    frame_scoreboard sb;
    result_t         seen;
    int              sender_idle_pct;
    int              receiver_idle_pct;
    bit              hold_receiver;
    int              frame_bytes_sent;
    int              cycle_count;
    logic [7:0]      cur_start;
    logic [5:0]      cur_max;

    crc_checked_frame_receiver_top dut (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_rx_byte(s_rx_byte);
            if (m_valid && m_ready) begin
                seen.event_res     = m_event_res;
                seen.frame_length  = m_frame_length;
                seen.command       = m_command;
                seen.byte_index    = m_byte_index;
                seen.payload_byte  = m_payload_byte;
                seen.payload_valid = m_payload_valid;
                seen.last          = m_last;
                seen.good_frames   = m_good_frames;
                seen.bad_frames    = m_bad_frames;
                sb.check_result(seen);
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Cycle limit of %0d reached with %0d results outstanding",
                 CYCLE_LIMIT, sb.pending_count());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // hold off the result channel on request, otherwise stall at random
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_receiver) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_receiver = 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
            end
        end
    end

    task automatic send_byte(input logic [7:0] value);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < sender_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_frame(input int len, input logic [7:0] cmd, input bit corrupt);
        logic [15:0] crc;
        logic [7:0]  data;
        send_byte(cur_start);
        send_byte(8'(len));
        crc = crc16_next(CRC_INIT, 8'(len));
        send_byte(cmd);
        crc = crc16_next(crc, cmd);
        for (int i = 0; i < len; i++) begin
            data = 8'($urandom_range(0, 255));
            send_byte(data);
            crc = crc16_next(crc, data);
        end
        if (corrupt) crc ^= 16'($urandom_range(1, 16'hFFFF));
        send_byte(crc[15:8]);
        send_byte(crc[7:0]);
        frame_bytes_sent += len + 5;
    endtask

    task automatic send_bad_length(input logic [7:0] len);
        send_byte(cur_start);
        send_byte(len);
        frame_bytes_sent += 2;
    endtask

    task automatic send_noise(input int count);
        logic [7:0] v;
        for (int i = 0; i < count; i++) begin
            v = 8'($urandom_range(0, 255));
            if (v == cur_start && $urandom_range(0, 3) != 0) v = ~v;
            send_byte(v);
        end
    endtask

    task automatic write_cfg(input logic idx, input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.write_register(idx, value);
        if (idx == CFG_START_BYTE) begin
            cur_start = value;
        end else begin
            cur_max = value[5:0];
        end
        @(posedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_count() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic send_random_traffic(input int goal);
        int limit;
        int kind;
        int len;
        int stop;
        stop = frame_bytes_sent + goal;
        while (frame_bytes_sent < stop) begin
            limit = (cur_max > PAYLOAD_DEPTH) ? PAYLOAD_DEPTH : cur_max;
            kind  = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0) begin
                len = $urandom_range(0, limit);
            end else begin
                len = $urandom_range(0, (limit < 4) ? limit : 4);
            end
            if (kind < 70) begin
                send_frame(len, 8'($urandom_range(0, 255)), 1'b0);
            end else if (kind < 80) begin
                send_frame(len, 8'($urandom_range(0, 255)), 1'b1);
            end else if (kind < 90) begin
                send_bad_length((kind < 85) ? 8'(limit + 1) : 8'($urandom_range(limit + 1, 255)));
            end else begin
                send_noise($urandom_range(1, 4));
            end
        end
    endtask

    initial begin
        sb                = new();
        sender_idle_pct   = 10;
        receiver_idle_pct = 63;
        hold_receiver     = 1'b0;
        frame_bytes_sent  = 0;
        cur_start         = START_BYTE_RESET;
        cur_max           = MAX_LENGTH_RESET;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(0, 8'hFF, 1'b0);
        send_frame(1, 8'h00, 1'b0);
        send_bad_length(8'hFF);
        send_bad_length(8'd33);
        send_frame(2, 8'h5A, 1'b1);
        drain_results();

        write_cfg(CFG_START_BYTE, 8'h00);
        write_cfg(CFG_MAX_LENGTH, 8'd63);
        send_random_traffic(100);

        // hold the receiver while a full-size frame and more traffic arrive
        hold_receiver = 1'b1;
        send_frame(PAYLOAD_DEPTH, 8'($urandom_range(0, 255)), 1'b0);
        send_random_traffic(30);
        drain_results();

        sender_idle_pct   = 63;
        receiver_idle_pct = 10;
        write_cfg(CFG_START_BYTE, 8'hFF);
        write_cfg(CFG_MAX_LENGTH, 8'd0);
        send_random_traffic(30);
        drain_results();

        write_cfg(CFG_START_BYTE, 8'($urandom_range(0, 255)));
        write_cfg(CFG_MAX_LENGTH, 8'($urandom_range(1, 31)));
        send_random_traffic(100);
        drain_results();

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        write_cfg(CFG_MAX_LENGTH, 8'hE0);
        write_cfg(CFG_START_BYTE, 8'($urandom_range(0, 255)));
        send_random_traffic(110);
        drain_results();

        $display("Checked %0d results from %0d frame bytes: %0d good and %0d bad frames.",
                 sb.results_checked, frame_bytes_sent, sb.good_total, sb.bad_total);
        $display("Limits 0, 32, 63 and random; sender, receiver and no stalls; long output hold.");
        if (sb.error_count == 0 && sb.pending_count() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
